FILE: hw/rtl/sdsr_pkg.sv
// shared types, register indexes, shape codes and palette rom of the sprite dot shape renderer
`timescale 1ns / 1ps
package sdsr_pkg;

	localparam int unsigned COLOR_W = 24;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned CODE_W  = 4;
	localparam int unsigned BENT_W  = 2;
	localparam int unsigned SHAPE_W = 3;
	localparam int unsigned INDEX_W = 3;

	// register indexes of the configuration port
	localparam logic [INDEX_W-1:0] REG_BACKGROUND_COLOR = 3'd0;
	localparam logic [INDEX_W-1:0] REG_COLUMN_MIN       = 3'd1;
	localparam logic [INDEX_W-1:0] REG_COLUMN_MAX       = 3'd2;
	localparam logic [INDEX_W-1:0] REG_ROW_MIN          = 3'd3;
	localparam logic [INDEX_W-1:0] REG_ROW_MAX          = 3'd4;

	localparam logic [POS_W-1:0] COLUMN_MAX_RESET = 8'd127;
	localparam logic [POS_W-1:0] ROW_MAX_RESET    = 8'd63;

	// dot shape codes
	localparam logic [SHAPE_W-1:0] SHAPE_NONE       = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_NORMAL     = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_BENT1_START = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_BENT1_END   = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_BENT2_START = 3'd4;
	localparam logic [SHAPE_W-1:0] SHAPE_BENT2_END   = 3'd5;

	// bent type codes
	localparam logic [BENT_W-1:0] BENT_NONE = 2'd0;
	localparam logic [BENT_W-1:0] BENT_ONE  = 2'd1;
	localparam logic [BENT_W-1:0] BENT_TWO  = 2'd2;
	localparam logic [BENT_W-1:0] BENT_BOTH = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]  dot_column;
		logic [POS_W-1:0]  line_number;
		logic [CODE_W-1:0] rgb_code;
		logic              bent_active;
		logic [BENT_W-1:0] bent_rise_bits;
		logic [BENT_W-1:0] bent_fall_bits;
		logic              color_enable;
		logic              first_of_line;
	} dot_t;

	typedef struct packed {
		logic [POS_W-1:0]   out_column;
		logic [POS_W-1:0]   out_line;
		logic [COLOR_W-1:0] dot_color;
		logic [SHAPE_W-1:0] dot_shape;
		logic               visible;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic [COLOR_W-1:0] background_color;
		logic [POS_W-1:0]   column_min;
		logic [POS_W-1:0]   column_max;
		logic [POS_W-1:0]   row_min;
		logic [POS_W-1:0]   row_max;
	} cfg_t;

	// classified dot as it waits between front and back
	typedef struct packed {
		logic [POS_W-1:0]   column;
		logic [POS_W-1:0]   line;
		logic [COLOR_W-1:0] main_color;
		logic [SHAPE_W-1:0] main_shape;
		logic               visible;
		logic               has_tail;
		logic [COLOR_W-1:0] tail_color;
		logic [SHAPE_W-1:0] tail_shape;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

	function automatic logic [COLOR_W-1:0] palette(input logic [CODE_W-1:0] code);
		logic [COLOR_W-1:0] rgb;
		case (code)
			4'd0:    rgb = 24'h000000;
			4'd1:    rgb = 24'h84C3CC;
			4'd2:    rgb = 24'hB0DF0B;
			4'd3:    rgb = 24'h62CEAA;
			4'd4:    rgb = 24'hFF81C4;
			4'd5:    rgb = 24'hD088CB;
			4'd6:    rgb = 24'hFFA11F;
			4'd7:    rgb = 24'hD0D0D0;
			4'd8:    rgb = 24'h000000;
			4'd9:    rgb = 24'h84C3CC;
			4'd10:   rgb = 24'hB0DF0B;
			4'd11:   rgb = 24'hA4EA96;
			4'd12:   rgb = 24'hFF87BE;
			4'd13:   rgb = 24'hC6B1FF;
			4'd14:   rgb = 24'hFFA022;
			4'd15:   rgb = 24'hD0D0D0;
			default: rgb = 24'h000000;
		endcase
		return rgb;
	endfunction

endpackage

FILE: hw/rtl/sdsr_if.sv
// valid/ready channel interfaces for dot words and result words
`timescale 1ns / 1ps
interface sdsr_dot_if;
	logic          valid;
	logic          ready;
	sdsr_pkg::dot_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdsr_res_if;
	logic             valid;
	logic             ready;
	sdsr_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sdsr_front.sv
// front end: takes dot words, tracks bent state and classifies each dot
`timescale 1ns / 1ps
module sdsr_front (
	input  logic                clk,
	input  logic                arst_n,
	sdsr_dot_if.sink            dots,
	input  sdsr_pkg::cfg_t      cfg,
	input  logic                queue_full,
	output sdsr_pkg::push_t     push
);

	logic [sdsr_pkg::BENT_W-1:0] bent_type_q;
	logic [sdsr_pkg::BENT_W-1:0] prev_bent_type_q;
	logic                        prev_bent_active_q;
	logic [sdsr_pkg::CODE_W-1:0] prev_rgb_code_q;

	logic [sdsr_pkg::BENT_W-1:0] bent_base;
	logic [sdsr_pkg::BENT_W-1:0] prev_bt;
	logic                        prev_ba;
	logic [sdsr_pkg::CODE_W-1:0] prev_code;
	logic [sdsr_pkg::BENT_W-1:0] bent_now;
	logic [sdsr_pkg::COLOR_W-1:0] color;
	logic [sdsr_pkg::SHAPE_W-1:0] shape;
	logic [sdsr_pkg::SHAPE_W-1:0] tail;
	logic                        vis;
	logic                        accept;
	sdsr_pkg::dot_t              d;

	assign d          = dots.data;
	assign dots.ready = !queue_full;
	assign accept     = dots.valid && !queue_full;

	always_comb begin
		// first dot of a line starts from cleared state
		bent_base = d.first_of_line ? sdsr_pkg::BENT_NONE : bent_type_q;
		prev_bt   = d.first_of_line ? sdsr_pkg::BENT_NONE : prev_bent_type_q;
		prev_ba   = d.first_of_line ? 1'b0 : prev_bent_active_q;
		prev_code = d.first_of_line ? '0 : prev_rgb_code_q;
		bent_now  = bent_base | d.bent_rise_bits;

		color = (d.rgb_code != '0) ? sdsr_pkg::palette(d.rgb_code) : cfg.background_color;
		// bent with no type is cancelled to background
		if (d.bent_active && bent_now == sdsr_pkg::BENT_NONE)
			color = cfg.background_color;

		shape = d.color_enable ? sdsr_pkg::SHAPE_NORMAL : sdsr_pkg::SHAPE_NONE;
		if (!prev_ba && d.bent_active) begin
			case (bent_now)
				sdsr_pkg::BENT_ONE:  shape = sdsr_pkg::SHAPE_BENT1_START;
				sdsr_pkg::BENT_TWO:  shape = sdsr_pkg::SHAPE_BENT2_START;
				sdsr_pkg::BENT_BOTH: shape = sdsr_pkg::SHAPE_NORMAL;
				default:             shape = shape;
			endcase
		end

		tail = shape;
		case (prev_bt)
			sdsr_pkg::BENT_ONE:  tail = sdsr_pkg::SHAPE_BENT1_END;
			sdsr_pkg::BENT_TWO:  tail = sdsr_pkg::SHAPE_BENT2_END;
			sdsr_pkg::BENT_BOTH: tail = sdsr_pkg::SHAPE_NORMAL;
			default:             tail = shape;
		endcase

		vis = (d.dot_column >= cfg.column_min) && (d.dot_column <= cfg.column_max) &&
			(d.line_number >= cfg.row_min) && (d.line_number <= cfg.row_max);

		push.push             = accept;
		push.entry.column     = d.dot_column;
		push.entry.line       = d.line_number;
		push.entry.main_color = color;
		push.entry.main_shape = shape;
		push.entry.visible    = vis;
		push.entry.has_tail   = prev_ba && !d.bent_active;
		// trailing end shape uses the raw palette, code zero is black
		push.entry.tail_color = sdsr_pkg::palette(prev_code);
		push.entry.tail_shape = tail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bent_type_q        <= sdsr_pkg::BENT_NONE;
			prev_bent_type_q   <= sdsr_pkg::BENT_NONE;
			prev_bent_active_q <= 1'b0;
			prev_rgb_code_q    <= '0;
		end else if (accept) begin
			prev_bent_type_q   <= bent_now;
			bent_type_q        <= bent_now & ~d.bent_fall_bits;
			prev_bent_active_q <= d.bent_active;
			prev_rgb_code_q    <= d.rgb_code;
		end
	end

endmodule

FILE: hw/rtl/sdsr_queue.sv
// two-entry queue of classified dots between front and back
`timescale 1ns / 1ps
module sdsr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  sdsr_pkg::push_t push,
	input  logic            pop,
	output logic            full,
	output sdsr_pkg::head_t head
);

	sdsr_pkg::entry_t entries_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full       = count_q[1];
	assign head.valid = (count_q != 2'd0);
	assign head.entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push)
			entries_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push.push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/sdsr_back.sv
// back end: sends one or two result words per classified dot through an output register
`timescale 1ns / 1ps
module sdsr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sdsr_pkg::head_t head,
	output logic            pop,
	sdsr_res_if.source      results
);

	logic              out_valid_q;
	logic              tail_next_q;
	sdsr_pkg::result_t out_q;
	logic              load;
	sdsr_pkg::result_t nxt;

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	assign load = head.valid && (!out_valid_q || results.ready);
	// entry leaves the queue once its last word is loaded
	assign pop  = load && (!head.entry.has_tail || tail_next_q);

	always_comb begin
		nxt.out_column = head.entry.column;
		nxt.out_line   = head.entry.line;
		nxt.visible    = head.entry.visible;
		if (tail_next_q) begin
			nxt.dot_color   = head.entry.tail_color;
			nxt.dot_shape   = head.entry.tail_shape;
			nxt.last_result = 1'b1;
		end else begin
			nxt.dot_color   = head.entry.main_color;
			nxt.dot_shape   = head.entry.main_shape;
			nxt.last_result = !head.entry.has_tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tail_next_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			if (load)
				tail_next_q <= head.entry.has_tail && !tail_next_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= nxt;
	end

endmodule

FILE: hw/rtl/sprite_dot_shape_render_top.sv
// top level of the sprite dot shape renderer: config registers, front, queue and back
// a dot word is held in the queue and then in the back end output register before its first result word is valid
// throughput: one dot word per cycle while the queue is not full; a dot that ends a bent gives two result words
// the output register in the back end sends one result word per cycle while results.ready is high
// reset clears bent state, queue, output valid and config registers to their defaults
`timescale 1ns / 1ps
module sprite_dot_shape_render_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sdsr_dot_if.sink                             dots,
	sdsr_res_if.source                           results,
	input  logic                                 cfg_wr_en,
	input  logic [sdsr_pkg::INDEX_W-1:0]         cfg_index,
	input  logic [sdsr_pkg::COLOR_W-1:0]         cfg_data
);

	sdsr_pkg::cfg_t  cfg_q;
	sdsr_pkg::push_t push;
	sdsr_pkg::head_t head;
	logic            queue_full;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.background_color <= '0;
			cfg_q.column_min       <= '0;
			cfg_q.column_max       <= sdsr_pkg::COLUMN_MAX_RESET;
			cfg_q.row_min          <= '0;
			cfg_q.row_max          <= sdsr_pkg::ROW_MAX_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sdsr_pkg::REG_BACKGROUND_COLOR: cfg_q.background_color <= cfg_data;
				sdsr_pkg::REG_COLUMN_MIN: cfg_q.column_min <= cfg_data[sdsr_pkg::POS_W-1:0];
				sdsr_pkg::REG_COLUMN_MAX: cfg_q.column_max <= cfg_data[sdsr_pkg::POS_W-1:0];
				sdsr_pkg::REG_ROW_MIN:    cfg_q.row_min    <= cfg_data[sdsr_pkg::POS_W-1:0];
				sdsr_pkg::REG_ROW_MAX:    cfg_q.row_max    <= cfg_data[sdsr_pkg::POS_W-1:0];
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	sdsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.dots       (dots),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push)
	);

	sdsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.head   (head)
	);

	sdsr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

FILE: tb/tb_sprite_dot_shape_render_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the sprite dot shape renderer: directed and random dot lines
module tb_sprite_dot_shape_render_top;

	localparam int STALL_LIMIT    = 2000;
	localparam int PHASES         = 8;
	localparam int DOTS_PER_PHASE = 140;
	localparam int IDLE_PCT       = 61;
	localparam int BOTH_IDLE_PCT  = 14;

	// predicts the result words of each dot word and checks them in order
	class dot_scoreboard;
		sdsr_pkg::cfg_t                      regs;
		logic [sdsr_pkg::COLOR_W-1:0]        rom [16];
		logic [sdsr_pkg::BENT_W-1:0]         bent_kind;
		logic [sdsr_pkg::BENT_W-1:0]         last_kind;
		logic                                last_active;
		logic [sdsr_pkg::CODE_W-1:0]         last_code;
		sdsr_pkg::result_t                   pending [$];
		int                                  errors;
		int                                  dots_seen;
		int                                  words_checked;
		int                                  tails;

		function new();
			rom = '{24'h000000, 24'h84C3CC, 24'hB0DF0B, 24'h62CEAA,
				24'hFF81C4, 24'hD088CB, 24'hFFA11F, 24'hD0D0D0,
				24'h000000, 24'h84C3CC, 24'hB0DF0B, 24'hA4EA96,
				24'hFF87BE, 24'hC6B1FF, 24'hFFA022, 24'hD0D0D0};
			regs.background_color = '0;
			regs.column_min = '0;
			regs.column_max = sdsr_pkg::COLUMN_MAX_RESET;
			regs.row_min = '0;
			regs.row_max = sdsr_pkg::ROW_MAX_RESET;
			clear_line();
			errors = 0;
			dots_seen = 0;
			words_checked = 0;
			tails = 0;
		endfunction

		function void clear_line();
			bent_kind = sdsr_pkg::BENT_NONE;
			last_kind = sdsr_pkg::BENT_NONE;
			last_active = 1'b0;
			last_code = '0;
		endfunction

		function void set_reg(input logic [sdsr_pkg::INDEX_W-1:0] idx,
			input logic [sdsr_pkg::COLOR_W-1:0] val);
			case (idx)
				sdsr_pkg::REG_BACKGROUND_COLOR: regs.background_color = val;
				sdsr_pkg::REG_COLUMN_MIN: regs.column_min = val[sdsr_pkg::POS_W-1:0];
				sdsr_pkg::REG_COLUMN_MAX: regs.column_max = val[sdsr_pkg::POS_W-1:0];
				sdsr_pkg::REG_ROW_MIN: regs.row_min = val[sdsr_pkg::POS_W-1:0];
				sdsr_pkg::REG_ROW_MAX: regs.row_max = val[sdsr_pkg::POS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_dot(input sdsr_pkg::dot_t d);
			sdsr_pkg::result_t            word;
			logic [sdsr_pkg::SHAPE_W-1:0] tail_shape;
			dots_seen++;
			if (d.first_of_line)
				clear_line();
			bent_kind = bent_kind | d.bent_rise_bits;
			word.out_column = d.dot_column;
			word.out_line = d.line_number;
			word.dot_color = (d.rgb_code != '0) ? rom[d.rgb_code] : regs.background_color;
			// inside a bent with no type bits the dot is cancelled
			if (d.bent_active && bent_kind == sdsr_pkg::BENT_NONE)
				word.dot_color = regs.background_color;
			word.dot_shape = d.color_enable ? sdsr_pkg::SHAPE_NORMAL : sdsr_pkg::SHAPE_NONE;
			if (!last_active && d.bent_active) begin
				case (bent_kind)
					sdsr_pkg::BENT_ONE: word.dot_shape = sdsr_pkg::SHAPE_BENT1_START;
					sdsr_pkg::BENT_TWO: word.dot_shape = sdsr_pkg::SHAPE_BENT2_START;
					sdsr_pkg::BENT_BOTH: word.dot_shape = sdsr_pkg::SHAPE_NORMAL;
					default: ;
				endcase
			end
			word.visible = d.dot_column >= regs.column_min && d.dot_column <= regs.column_max &&
				d.line_number >= regs.row_min && d.line_number <= regs.row_max;
			word.last_result = 1'b1;
			if (last_active && !d.bent_active) begin
				tail_shape = word.dot_shape;
				case (last_kind)
					sdsr_pkg::BENT_ONE: tail_shape = sdsr_pkg::SHAPE_BENT1_END;
					sdsr_pkg::BENT_TWO: tail_shape = sdsr_pkg::SHAPE_BENT2_END;
					sdsr_pkg::BENT_BOTH: tail_shape = sdsr_pkg::SHAPE_NORMAL;
					default: ;
				endcase
				word.last_result = 1'b0;
				pending.push_back(word);
				// trailing word takes the previous code straight from the rom
				word.dot_color = rom[last_code];
				word.dot_shape = tail_shape;
				word.last_result = 1'b1;
				tails++;
			end
			pending.push_back(word);
			last_kind = bent_kind;
			bent_kind = bent_kind & ~d.bent_fall_bits;
			last_active = d.bent_active;
			last_code = d.rgb_code;
		endfunction

		function void check_field(input string label,
			input logic [sdsr_pkg::COLOR_W-1:0] want,
			input logic [sdsr_pkg::COLOR_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, label, want, got);
			end
		endfunction

		function void check_word(input sdsr_pkg::result_t got);
			sdsr_pkg::result_t want;
			words_checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result word expected none got %h", $time, got);
				return;
			end
			want = pending.pop_front();
			check_field("out_column", 24'(want.out_column), 24'(got.out_column));
			check_field("out_line", 24'(want.out_line), 24'(got.out_line));
			check_field("dot_color", want.dot_color, got.dot_color);
			check_field("dot_shape", 24'(want.dot_shape), 24'(got.dot_shape));
			check_field("visible", 24'(want.visible), 24'(got.visible));
			check_field("last_result", 24'(want.last_result), 24'(got.last_result));
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [sdsr_pkg::INDEX_W-1:0] cfg_index;
	logic [sdsr_pkg::COLOR_W-1:0] cfg_data;

	sdsr_dot_if dot_ch ();
	sdsr_res_if res_ch ();

	dot_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int dots_sent = 0;
	int phases_run = 0;

	sprite_dot_shape_render_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.dots(dot_ch),
		.results(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (dot_ch.valid && dot_ch.ready)
			sb.note_dot(dot_ch.data);
		if (res_ch.valid && res_ch.ready)
			sb.check_word(res_ch.data);
		if ((dot_ch.valid && dot_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic sdsr_pkg::dot_t make_dot(input int col, input int row,
		input int code, input int act, input int rise,
		input int fall, input int cen, input int first);
		sdsr_pkg::dot_t d;
		d.dot_column = 8'(col);
		d.line_number = 8'(row);
		d.rgb_code = 4'(code);
		d.bent_active = 1'(act);
		d.bent_rise_bits = 2'(rise);
		d.bent_fall_bits = 2'(fall);
		d.color_enable = 1'(cen);
		d.first_of_line = 1'(first);
		return d;
	endfunction

	function automatic sdsr_pkg::cfg_t phase_cfg(input int p);
		sdsr_pkg::cfg_t             c;
		logic [sdsr_pkg::POS_W-1:0] swap;
		c.background_color = 24'($urandom);
		c.column_min = 8'($urandom);
		c.column_max = 8'($urandom);
		c.row_min = 8'($urandom);
		c.row_max = 8'($urandom);
		if (c.column_min > c.column_max) begin
			swap = c.column_min;
			c.column_min = c.column_max;
			c.column_max = swap;
		end
		if (c.row_min > c.row_max) begin
			swap = c.row_min;
			c.row_min = c.row_max;
			c.row_max = swap;
		end
		case (p)
			0, 7: begin
				c.background_color = '1;
				c.column_min = '0;
				c.column_max = '1;
				c.row_min = '0;
				c.row_max = '1;
			end
			1: begin
				// single visible dot at the far corner of the columns
				c.column_min = '1;
				c.column_max = '1;
				c.row_min = '0;
				c.row_max = '0;
			end
			2: begin
				// minimum above maximum: nothing visible
				c.column_min = 8'd200;
				c.column_max = 8'd10;
			end
			4: begin
				c.background_color = '0;
				c.row_min = '1;
				c.row_max = '1;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic send_dot(input sdsr_pkg::dot_t d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			dot_ch.valid <= 1'b0;
			@(posedge clk);
		end
		dot_ch.valid <= 1'b1;
		dot_ch.data <= d;
		do
			@(posedge clk);
		while (!(dot_ch.valid && dot_ch.ready));
		dots_sent++;
	endtask

	task automatic write_reg(input logic [sdsr_pkg::INDEX_W-1:0] idx,
		input logic [sdsr_pkg::COLOR_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic apply_config(input sdsr_pkg::cfg_t c);
		write_reg(sdsr_pkg::REG_BACKGROUND_COLOR, c.background_color);
		write_reg(sdsr_pkg::REG_COLUMN_MIN, 24'(c.column_min));
		write_reg(sdsr_pkg::REG_COLUMN_MAX, 24'(c.column_max));
		write_reg(sdsr_pkg::REG_ROW_MIN, 24'(c.row_min));
		write_reg(sdsr_pkg::REG_ROW_MAX, 24'(c.row_max));
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain();
		dot_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// one scan line: mostly well-formed bent spans, with some noise words
	task automatic send_line(input int n);
		sdsr_pkg::dot_t             d;
		logic [31:0]                r;
		logic [sdsr_pkg::POS_W-1:0] col0;
		logic [sdsr_pkg::POS_W-1:0] row;
		bit                         in_bent;
		col0 = 8'($urandom);
		row = 8'($urandom);
		in_bent = 1'b0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				r = $urandom;
				d = r[$bits(sdsr_pkg::dot_t)-1:0];
			end else begin
				d.first_of_line = (i == 0);
				d.dot_column = col0 + 8'(i);
				d.line_number = row;
				d.rgb_code = 4'($urandom_range(0, 15));
				d.color_enable = 1'($urandom_range(0, 1));
				if (!in_bent && $urandom_range(0, 3) == 0) begin
					in_bent = 1'b1;
					d.bent_active = 1'b1;
					d.bent_rise_bits = 2'(($urandom_range(0, 5) == 0) ? 0 :
						$urandom_range(1, 3));
				end else begin
					d.bent_active = in_bent;
					d.bent_rise_bits = 2'(($urandom_range(0, 7) == 0) ?
						$urandom_range(1, 3) : 0);
				end
				if (in_bent && $urandom_range(0, 2) == 0) begin
					d.bent_fall_bits = 2'(($urandom_range(0, 4) == 0) ?
						$urandom_range(0, 3) : 3);
					in_bent = 1'b0;
				end else begin
					d.bent_fall_bits = 2'(($urandom_range(0, 9) == 0) ?
						$urandom_range(1, 3) : 0);
				end
			end
			send_dot(d);
		end
	endtask

	initial begin
		int target;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= sdsr_pkg::REG_BACKGROUND_COLOR;
		cfg_data <= '0;
		dot_ch.valid <= 1'b0;
		dot_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed dots against the reset register values
		send_dot(make_dot(0, 0, 0, 0, 0, 0, 0, 1));
		send_dot(make_dot(255, 255, 15, 0, 0, 0, 1, 0));
		send_dot(make_dot(127, 63, 8, 0, 0, 0, 1, 0));
		send_dot(make_dot(128, 63, 7, 0, 0, 0, 0, 0));
		send_dot(make_dot(127, 64, 1, 0, 0, 0, 1, 0));
		// bent of type one: start, hold, end
		send_dot(make_dot(10, 5, 5, 1, 1, 0, 0, 0));
		send_dot(make_dot(11, 5, 9, 1, 0, 1, 1, 0));
		send_dot(make_dot(12, 5, 3, 0, 0, 0, 1, 0));
		// type two left set after its end, so the next bent starts as type two again
		send_dot(make_dot(13, 5, 6, 1, 2, 0, 1, 0));
		send_dot(make_dot(14, 5, 0, 0, 0, 0, 0, 0));
		send_dot(make_dot(15, 5, 12, 1, 0, 2, 0, 0));
		send_dot(make_dot(16, 5, 11, 0, 0, 0, 1, 0));
		// both type bits give the normal shape at start and end
		send_dot(make_dot(17, 5, 13, 1, 3, 3, 0, 0));
		send_dot(make_dot(18, 5, 14, 0, 0, 0, 0, 0));
		// bent with no type bits: background colour, shape from color_enable
		send_dot(make_dot(19, 5, 4, 1, 0, 0, 1, 0));
		send_dot(make_dot(20, 5, 2, 0, 0, 0, 0, 0));
		// new line in the middle of a bent drops the tail
		send_dot(make_dot(21, 5, 10, 1, 1, 0, 1, 0));
		send_dot(make_dot(0, 6, 0, 0, 0, 0, 1, 1));
		// tail of code zero is black
		send_dot(make_dot(1, 6, 0, 1, 2, 3, 0, 0));
		send_dot(make_dot(2, 6, 15, 0, 0, 0, 1, 0));
		send_dot(make_dot(255, 255, 15, 1, 3, 3, 1, 1));
		send_dot(make_dot(254, 0, 8, 0, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			apply_config(phase_cfg(p));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = IDLE_PCT;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = IDLE_PCT;
				end
				default: begin
					send_idle_pct = BOTH_IDLE_PCT;
					recv_stall_pct = BOTH_IDLE_PCT;
				end
			endcase
			target = dots_sent + DOTS_PER_PHASE;
			while (dots_sent < target)
				send_line($urandom_range(4, 24));
			drain();
			phases_run++;
		end

		if (sb.pending.size() != 0)
			$display("%0t: %0d expected result words never arrived", $time, sb.pending.size());
		$display("%0d dot words over %0d register settings plus reset values", sb.dots_seen,
			phases_run);
		$display("%0d result words checked, %0d of them bent end tails, %0d mismatches",
			sb.words_checked, sb.tails, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
